// ===== hw/rtl/pfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants, codes and types of the packet filler / checksum generator.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int COUNT_BITS       = 24;
    localparam int HEADER_BYTES     = 24;
    localparam int SEC_HEADER_BYTES = 12;
    localparam int LEN_W            = 25;
    localparam int PAD_W            = COUNT_BITS + 1;
    localparam int TOT_W            = (PAD_W + 1 > LEN_W) ? PAD_W + 1 : LEN_W;
    localparam int DATA_W           = 8;
    localparam int SUM_W            = 32;
    localparam int CFG_W            = 2;
    localparam int M_TDATA_W        = ((DATA_W + LEN_W + 1 + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [0:0] REG_CHECKSUM_MODE = 1'b0;
    localparam logic [0:0] REG_SEC_HEADER_ON = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_SUM8  = 2'd1,
        MODE_SUM16 = 2'd2,
        MODE_SUM32 = 2'd3
    } csum_mode_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_FILL = 2'd1,
        KIND_CSUM = 2'd2
    } byte_kind_t;

    // Everything the tail sequencer needs to emit the words of one input byte
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              ovf;
        logic              sec;
        logic [1:0]        fill;
        logic [2:0]        csum_bytes;
        logic [2:0]        n_last;
        logic [SUM_W-1:0]  sum;
        logic [PAD_W-1:0]  padded;
    } desc_t;

endpackage

// ===== hw/rtl/pfc_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_accum
// Byte counter and running checksum; builds the emit descriptor of each byte.
// ----------------------------------------------------------------------------
module pfc_accum (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_fire,
    input  logic [pfc_pkg::DATA_W-1:0] in_data,
    input  logic                      in_last,
    input  pfc_pkg::csum_mode_t       mode,
    input  logic                      sec_on,
    output pfc_pkg::desc_t            desc
);
    import pfc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] count_reg, count_next, count_upd;
    logic [SUM_W-1:0]      sum_reg, sum_next, sum_upd, addend;
    logic                  ovf_reg, ovf_next, ovf_upd;
    logic [1:0]            lane;
    logic                  sat;
    logic [2:0]            cs;
    logic [1:0]            fill;

    always_comb begin
        case (mode)
            MODE_SUM16: lane = {1'b0, count_reg[0]};
            MODE_SUM32: lane = count_reg[1:0];
            default:    lane = 2'd0;
        endcase
        case (mode)
            MODE_SUM8:  cs = 3'd1;
            MODE_SUM16: cs = 3'd2;
            MODE_SUM32: cs = 3'd4;
            default:    cs = 3'd0;
        endcase
    end

    assign addend  = SUM_W'(in_data) << {lane, 3'b000};
    assign sum_upd = (mode != MODE_NONE) ? sum_reg + addend : sum_reg;

    // Saturate at full scale and flag the overflow
    assign sat       = (count_reg == COUNT_MAX);
    assign count_upd = sat ? count_reg : count_reg + 1'b1;
    assign ovf_upd   = ovf_reg | sat;

    // Pad body plus checksum to a four-byte boundary
    assign fill = 2'd0 - (count_upd[1:0] + cs[1:0]);

    always_comb begin
        desc.data       = in_data;
        desc.last       = in_last;
        desc.ovf        = ovf_upd;
        desc.sec        = sec_on;
        desc.fill       = fill;
        desc.csum_bytes = cs;
        desc.n_last     = in_last ? 3'({1'b0, fill}) + cs : 3'd0;
        desc.sum        = sum_upd;
        desc.padded     = PAD_W'(count_upd) + PAD_W'(fill) + PAD_W'(cs);
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        if (in_fire) begin
            if (in_last) begin
                count_next = '0;
                sum_next   = '0;
                ovf_next   = 1'b0;
            end else begin
                count_next = count_upd;
                sum_next   = sum_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== hw/rtl/pfc_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_tail
// Holds one descriptor and emits its data, filler and checksum words.
// ----------------------------------------------------------------------------
module pfc_tail (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pfc_pkg::desc_t              desc_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pfc_pkg::DATA_W-1:0]  m_byte,
    output pfc_pkg::byte_kind_t         m_kind,
    output logic                        m_end,
    output logic [pfc_pkg::LEN_W-1:0]   m_length,
    output logic                        m_ovf
);
    import pfc_pkg::*;

    localparam logic [TOT_W-1:0] HDR_ONLY = TOT_W'(HEADER_BYTES);
    localparam logic [TOT_W-1:0] HDR_SEC  = TOT_W'(HEADER_BYTES + SEC_HEADER_BYTES);

    desc_t            desc_reg;
    logic             desc_valid_reg, desc_valid_next;
    logic [2:0]       step_reg, step_next;
    logic             out_valid_reg;
    logic [DATA_W-1:0] out_byte_reg, byte_next;
    byte_kind_t       out_kind_reg, kind_next;
    logic             out_end_reg, end_next;
    logic [LEN_W-1:0] out_len_reg, len_next;
    logic             out_ovf_reg;

    logic             load_out, emit, fin, fire;
    logic [2:0]       csum_idx;
    logic [TOT_W-1:0] total;

    assign load_out = !out_valid_reg || m_ready;
    assign emit     = desc_valid_reg && load_out;
    assign fin      = emit && (step_reg == desc_reg.n_last);
    assign in_ready = !desc_valid_reg || fin;
    assign fire     = in_valid && in_ready;

    assign csum_idx = step_reg - 3'd1 - 3'({1'b0, desc_reg.fill});
    assign total    = TOT_W'(desc_reg.padded) + (desc_reg.sec ? HDR_SEC : HDR_ONLY);

    always_comb begin
        if (step_reg == 3'd0) begin
            kind_next = KIND_DATA;
            byte_next = desc_reg.data;
        end else if (step_reg <= 3'({1'b0, desc_reg.fill})) begin
            kind_next = KIND_FILL;
            byte_next = '0;
        end else begin
            kind_next = KIND_CSUM;
            byte_next = desc_reg.sum[{csum_idx[1:0], 3'b000} +: DATA_W];
        end
        end_next = desc_reg.last && (step_reg == desc_reg.n_last);
        len_next = end_next ? total[LEN_W-1:0] : '0;
    end

    always_comb begin
        desc_valid_next = desc_valid_reg;
        step_next       = step_reg;
        if (fire) begin
            desc_valid_next = 1'b1;
            step_next       = 3'd0;
        end else if (fin) begin
            desc_valid_next = 1'b0;
        end else if (emit) begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_valid_reg <= 1'b0;
            step_reg       <= 3'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            desc_valid_reg <= desc_valid_next;
            step_reg       <= step_next;
            if (load_out) begin
                out_valid_reg <= desc_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            desc_reg <= desc_in;
        end
        if (emit) begin
            out_byte_reg <= byte_next;
            out_kind_reg <= kind_next;
            out_end_reg  <= end_next;
            out_len_reg  <= len_next;
            out_ovf_reg  <= desc_reg.ovf;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_byte   = out_byte_reg;
    assign m_kind   = out_kind_reg;
    assign m_end    = out_end_reg;
    assign m_length = out_len_reg;
    assign m_ovf    = out_ovf_reg;

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        desc_valid_reg |-> step_reg <= desc_reg.n_last)
        else $error("tail step ran past the last word of its descriptor");

    a_fresh_desc: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> desc_valid_reg && step_reg == 3'd0)
        else $error("accepted byte did not start at its data word");

    a_csum_needs_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && step_reg > 3'({1'b0, desc_reg.fill}) |-> desc_reg.csum_bytes != 3'd0)
        else $error("checksum word emitted with no checksum selected");

    a_len_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_end_reg |-> out_len_reg == '0)
        else $error("packet length shown on a word that does not end the packet");

endmodule

// ===== hw/rtl/packet_filler_checksum_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_filler_checksum_gen
// Packet body pass-through with zero filler, checksum append and length report.
// ----------------------------------------------------------------------------
// Body bytes enter on the s_ channel at one word per cycle while s_tready is
// high and leave on the m_ channel in order. The byte marked by s_tlast gives
// 1 + filler + checksum words (1 to 8): the tail sequencer holds its
// descriptor and drives one word a cycle into the single output register
// while m_tready allows, and s_tready stays low until its last word is loaded.
// Filler pads body plus checksum to a four-byte boundary; the checksum (none,
// 8-, 16- or 32-bit little-endian sum) follows least significant byte first.
// The final word carries m_tlast and the total packet length (header, optional
// secondary header, padded body and checksum); length_overflow is set once the
// body count has saturated. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module packet_filler_checksum_gen (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [0:0]                     cfg_addr,
    input  logic [pfc_pkg::CFG_W-1:0]      cfg_wdata,
    // Input body bytes
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // body_end
    // Output words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pfc_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte,
                                                      // [32:8] packet_length,
                                                      // [33] length_overflow
    output logic [1:0]                     m_tuser,   // [1:0] byte_kind
    output logic                           m_tlast    // packet_end
);
    import pfc_pkg::*;

    csum_mode_t         mode_reg;
    logic               sec_on_reg;
    desc_t              desc;
    logic               in_fire;
    logic [DATA_W-1:0]  out_byte;
    byte_kind_t         out_kind;
    logic [LEN_W-1:0]   out_len;
    logic               out_ovf;

    // Configuration registers: take the write on any enabled edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NONE;
            sec_on_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CHECKSUM_MODE: mode_reg   <= csum_mode_t'(cfg_wdata);
                REG_SEC_HEADER_ON: sec_on_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // A word enters when the tail sequencer can take a fresh descriptor
    assign in_fire = s_tvalid && s_tready;

    // Count, sum and build the descriptor of the arriving byte
    pfc_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_data (s_tdata),
        .in_last (s_tlast),
        .mode    (mode_reg),
        .sec_on  (sec_on_reg),
        .desc    (desc)
    );

    // Emit data, filler and checksum words through the output register
    pfc_tail u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .desc_in  (desc),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_byte   (out_byte),
        .m_kind   (out_kind),
        .m_end    (m_tlast),
        .m_length (out_len),
        .m_ovf    (out_ovf)
    );

    // Pack the output word, lowest field first, zero-fill to whole bytes
    assign m_tdata = M_TDATA_W'({out_ovf, out_len, out_byte});
    assign m_tuser = out_kind;

endmodule

// ===== tb/tb_packet_filler_checksum_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_filler_checksum_gen
// Self-checking bench for the packet filler / checksum generator.
// ----------------------------------------------------------------------------
// Body bytes go in on the s_ side and every output word is compared, field by
// field, with a model of the block held in this file: pass-through, zero
// filler to a four-byte boundary, the selected checksum least significant
// byte first, packet_end on the final word and the total packet length.
// A short table of hand-made packets runs first (empty fields, full fields,
// each checksum mode, the longest tail, a mode change inside a packet); about
// three hundred random body bytes follow in packets of mixed size under mixed
// settings. Both sides idle at random, the receiver holds off for a long
// stretch while bytes keep coming, and a watchdog ends a run that hangs.
// ----------------------------------------------------------------------------
module tb_packet_filler_checksum_gen;
    import pfc_pkg::*;

    localparam int IDLE_PERCENT    = 23;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;     // output register plus tail margin
    localparam int STALL_LIMIT     = 2000;  // quiet cycles before giving up
    localparam int RANDOM_BYTES    = 300;
    localparam int N_ROWS          = 24;
    localparam int MAX_PRINTS      = 40;

    // One word of the m_ channel as the model predicts it
    typedef struct packed {
        logic [7:0]       value;
        byte_kind_t       kind;
        logic             fin;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } out_word_t;

    // One row of the directed table; pinned rows carry the packet length and
    // checksum worked out by hand, which replace the model's figures
    typedef struct {
        csum_mode_t       mode;
        logic             sec;
        logic [7:0]       data;
        logic             last;
        logic             pin;
        logic [LEN_W-1:0] len;
        logic [31:0]      sum;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [0:0]            cfg_addr  = REG_CHECKSUM_MODE;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;  // [7:0] data_byte
    logic                  s_tlast   = 1'b0; // body_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [7:0] out_byte, [32:8] packet_length,
                                            // [33] length_overflow
    logic [1:0]            m_tuser;         // [1:0] byte_kind
    logic                  m_tlast;         // packet_end

    // Model state: settings in force and the packet being built
    csum_mode_t            cur_mode   = MODE_NONE;
    logic                  cur_sec    = 1'b0;
    logic [COUNT_BITS-1:0] body_bytes = '0;
    logic [31:0]           body_sum   = '0;
    logic                  body_ovf   = 1'b0;
    out_word_t             pending_words[$];

    // Run control and statistics
    logic                  idle_on       = 1'b1;
    int                    hold_reqs     = 0;
    int                    hold_seen     = 0;
    int                    hold_left     = 0;
    int                    quiet_cycles  = 0;
    int                    mismatch_count = 0;
    int                    words_checked = 0;
    int                    bytes_sent    = 0;
    int                    packets_sent  = 0;
    int                    longest_tail  = 0;
    logic [3:0]            modes_seen    = '0;

    stim_row_t directed_rows [N_ROWS] = '{
        // one byte, no checksum: three filler words, bare header length
        '{MODE_NONE,  1'b0, 8'h00, 1'b1, 1'b1, 25'd28, 32'h0},
        // same with the secondary header counted
        '{MODE_NONE,  1'b1, 8'hFF, 1'b1, 1'b1, 25'd40, 32'h0},
        // byte sum wraps past eight bits
        '{MODE_SUM8,  1'b0, 8'hFF, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM8,  1'b0, 8'hFF, 1'b1, 1'b1, 25'd28, 32'h1FE},
        // sixteen-bit sum across both lanes, secondary header on
        '{MODE_SUM16, 1'b1, 8'h01, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM16, 1'b1, 8'h80, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM16, 1'b1, 8'hFF, 1'b1, 1'b1, 25'd44, 32'h8100},
        // thirty-two-bit sum, body already aligned: no filler
        '{MODE_SUM32, 1'b0, 8'h11, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM32, 1'b0, 8'h22, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM32, 1'b0, 8'h33, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM32, 1'b0, 8'h44, 1'b1, 1'b1, 25'd32, 32'h44332211},
        // longest tail: data, three filler, four checksum
        '{MODE_SUM32, 1'b0, 8'hAA, 1'b1, 1'b1, 25'd32, 32'hAA},
        // packet end lands on the only checksum byte
        '{MODE_SUM8,  1'b0, 8'h55, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM8,  1'b0, 8'h55, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM8,  1'b0, 8'h55, 1'b1, 1'b1, 25'd28, 32'hFF},
        // no checksum, aligned body: packet end on the data word itself
        '{MODE_NONE,  1'b0, 8'h80, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_NONE,  1'b0, 8'h40, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_NONE,  1'b0, 8'h20, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_NONE,  1'b0, 8'h10, 1'b1, 1'b1, 25'd28, 32'h0},
        // mode changed inside a packet: lanes follow the mode of each byte
        '{MODE_SUM16, 1'b0, 8'h12, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM32, 1'b0, 8'h34, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM32, 1'b0, 8'h56, 1'b1, 1'b1, 25'd32, 32'h563412},
        // first byte unsummed, checksum switched on for the last
        '{MODE_NONE,  1'b0, 8'h77, 1'b0, 1'b0, 25'd0,  32'h0},
        '{MODE_SUM8,  1'b0, 8'h01, 1'b1, 1'b1, 25'd28, 32'h1}
    };

    packet_filler_checksum_gen u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------
    function automatic int checksum_bytes(input csum_mode_t mode);
        case (mode)
            MODE_SUM8:  return 1;
            MODE_SUM16: return 2;
            MODE_SUM32: return 4;
            default:    return 0;
        endcase
    endfunction

    function automatic out_word_t tail_word(input logic [7:0] value, input byte_kind_t kind,
                                            input logic fin, input logic [LEN_W-1:0] len,
                                            input logic ovf);
        return '{value, kind, fin, fin ? len : '0, ovf};
    endfunction

    // Fold one accepted body byte into the packet and queue the words it causes
    task automatic build_words(input logic [7:0] data, input logic last);
        logic [1:0]       lane;
        int               n_csum;
        int               n_fill;
        longint           padded;
        logic [LEN_W-1:0] len;
        lane = (cur_mode == MODE_SUM16) ? {1'b0, body_bytes[0]} :
               (cur_mode == MODE_SUM32) ? body_bytes[1:0] : 2'd0;
        if (cur_mode != MODE_NONE)
            body_sum += {24'd0, data} << (8 * lane);
        // saturate the byte count rather than wrap
        if (&body_bytes)
            body_ovf = 1'b1;
        else
            body_bytes++;
        if (!last) begin
            pending_words.push_back(tail_word(data, KIND_DATA, 1'b0, '0, body_ovf));
            return;
        end
        n_csum = checksum_bytes(cur_mode);
        padded = (longint'(body_bytes) + n_csum + 3) & ~longint'(3);
        n_fill = int'(padded - longint'(body_bytes)) - n_csum;
        len    = LEN_W'(padded + HEADER_BYTES + (cur_sec ? SEC_HEADER_BYTES : 0));
        pending_words.push_back(tail_word(data, KIND_DATA, (n_fill + n_csum) == 0, len,
                                          body_ovf));
        for (int i = 0; i < n_fill; i++)
            pending_words.push_back(tail_word(8'h00, KIND_FILL,
                                              (i == n_fill - 1) && (n_csum == 0), len,
                                              body_ovf));
        for (int i = 0; i < n_csum; i++)
            pending_words.push_back(tail_word(body_sum[8*i +: 8], KIND_CSUM,
                                              i == n_csum - 1, len, body_ovf));
        if (1 + n_fill + n_csum > longest_tail)
            longest_tail = 1 + n_fill + n_csum;
        modes_seen[cur_mode] = 1'b1;
        packets_sent++;
        body_bytes = '0;
        body_sum   = '0;
        body_ovf   = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Offer one byte, hold it until taken, then queue its words. Valid stays
    // high on return so back-to-back bytes need no extra edge.
    task automatic send_byte(input logic [7:0] data, input logic last, input logic pin,
                             input logic [LEN_W-1:0] pin_len, input logic [31:0] pin_sum);
        int        base;
        int        csum_idx;
        out_word_t w;
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        base = pending_words.size();
        build_words(data, last);
        bytes_sent++;
        // overwrite the model's length and checksum with the hand-made ones
        if (pin) begin
            csum_idx = 0;
            for (int j = base; j < pending_words.size(); j++) begin
                w = pending_words[j];
                if (w.kind == KIND_CSUM) begin
                    w.value = pin_sum[8*csum_idx +: 8];
                    csum_idx++;
                end
                if (w.fin)
                    w.len = pin_len;
                pending_words[j] = w;
            end
        end
    endtask

    // Drop valid and wait until every queued word is out and the tail is done
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; only called with the block settled
    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_CHECKSUM_MODE: cur_mode = csum_mode_t'(value);
            REG_SEC_HEADER_ON: cur_sec  = value[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] word %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, words_checked, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Output check: compare every accepted word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                note_mismatch("unexpected word, out_byte", {24'd0, m_tdata[7:0]}, 32'd0);
            end else begin
                want = pending_words.pop_front();
                if (m_tdata[7:0] !== want.value)
                    note_mismatch("out_byte", {24'd0, m_tdata[7:0]}, {24'd0, want.value});
                if (m_tuser !== want.kind)
                    note_mismatch("byte_kind", {30'd0, m_tuser}, {30'd0, want.kind});
                if (m_tlast !== want.fin)
                    note_mismatch("packet_end", {31'd0, m_tlast}, {31'd0, want.fin});
                if (m_tdata[8 +: LEN_W] !== want.len)
                    note_mismatch("packet_length", 32'(m_tdata[8 +: LEN_W]), 32'(want.len));
                if (m_tdata[8 + LEN_W] !== want.ovf)
                    note_mismatch("length_overflow", {31'd0, m_tdata[8 + LEN_W]},
                                  {31'd0, want.ovf});
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too long with no word moving either way
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d words still expected",
                     STALL_LIMIT, pending_words.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int       pkt_no;
        int       pkt_len;
        logic [1:0] new_mode;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: settle and rewrite a register wherever a row asks
        // for different settings, even in the middle of a packet
        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].mode != cur_mode || directed_rows[r].sec != cur_sec) begin
                settle();
                if (directed_rows[r].mode != cur_mode)
                    write_reg(REG_CHECKSUM_MODE, directed_rows[r].mode);
                if (directed_rows[r].sec != cur_sec)
                    write_reg(REG_SEC_HEADER_ON, {1'b0, directed_rows[r].sec});
            end
            send_byte(directed_rows[r].data, directed_rows[r].last, directed_rows[r].pin,
                      directed_rows[r].len, directed_rows[r].sum);
        end

        // Random packets: mostly short, now and then a long one
        pkt_no = 0;
        while (bytes_sent < N_ROWS + RANDOM_BYTES) begin
            // a stretch with no idling on either side
            idle_on = !(pkt_no >= 10 && pkt_no < 25);
            // long receiver hold-off while bytes keep coming, once with
            // random gaps and once flat out
            if (pkt_no == 4 || pkt_no == 14)
                hold_reqs++;
            // sender pause until everything is out
            if (pkt_no == 8)
                settle();
            // keep offering bytes while a hold-off is pending or running
            if (hold_left == 0 && hold_seen == hold_reqs && $urandom_range(2) == 0) begin
                settle();
                write_reg(REG_CHECKSUM_MODE, CFG_W'($urandom_range(3)));
                if ($urandom_range(1) == 0)
                    write_reg(REG_SEC_HEADER_ON, CFG_W'($urandom_range(3)));
            end
            pkt_len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
            for (int i = 0; i < pkt_len; i++) begin
                // rarely switch the mode between two bytes of one packet
                if (i > 0 && hold_left == 0 && hold_seen == hold_reqs &&
                    $urandom_range(49) == 0) begin
                    settle();
                    new_mode = 2'($urandom_range(3));
                    write_reg(REG_CHECKSUM_MODE, new_mode);
                end
                send_byte(8'($urandom_range(255)), i == pkt_len - 1, 1'b0, '0, '0);
            end
            pkt_no++;
        end

        settle();
        $display("Run covered %0d body bytes in %0d packets, %0d words checked",
                 bytes_sent, packets_sent, words_checked);
        $display("Checksum modes seen (3..0): %b, longest tail %0d words, two long hold-offs",
                 modes_seen, longest_tail);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_accum.sv
hw/rtl/pfc_tail.sv
hw/rtl/packet_filler_checksum_gen.sv
tb/tb_packet_filler_checksum_gen.sv
